FILE: rtl/tlvfr_pkg.sv
package tlvfr_pkg;

    // Field widths
    localparam int DataW        = 8;
    localparam int CfgW         = 17;
    localparam int CfgIdxW      = 3;
    localparam int SlotIdxW     = 3;
    localparam int StatusW      = 2;
    localparam int SlotCountDef = 6;

    // Slot register layout
    localparam int SlotValidBit = 16;
    localparam int SlotTypeLo   = 8;
    localparam int SlotAddrLo   = 0;

    // Queue between the front and the back
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [StatusW-1:0] {
        ST_DELIVERED = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_NO_SLOT   = 2'd2
    } t_status;

    // One classified request handed from the front to the back
    typedef struct packed {
        logic             last;     // checksum byte, frame ends
        logic             sum_ok;   // checksum matched (valid when last)
        logic [DataW-1:0] data;     // payload byte
        logic [DataW-1:0] addr;
        logic [DataW-1:0] ftype;
    } t_entry;

endpackage

FILE: rtl/tlvfr_front.sv
module tlvfr_front
    import tlvfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [DataW-1:0] i_rx_byte,
    input  logic             i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    typedef enum logic [4:0] {
        PH_ADDR    = 5'b00001,
        PH_TYPE    = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [DataW-1:0] r_addr, n_addr;
    logic [DataW-1:0] r_type, n_type;
    logic [DataW-1:0] r_remain, n_remain;
    logic [DataW-1:0] r_xor, n_xor;
    logic             accept;
    logic [DataW-1:0] remain_dec;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign remain_dec = r_remain - DataW'(1);

    // Walk the frame structure and classify each byte
    always_comb begin
        n_phase  = r_phase;
        n_addr   = r_addr;
        n_type   = r_type;
        n_remain = r_remain;
        n_xor    = r_xor;
        o_push   = 1'b0;
        o_entry  = '{last: 1'b0, sum_ok: 1'b0, data: i_rx_byte, addr: r_addr, ftype: r_type};
        if (accept) begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_remain = i_rx_byte;
                    n_xor    = r_xor ^ i_rx_byte;
                    n_phase  = (i_rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_xor    = r_xor ^ i_rx_byte;
                    n_remain = remain_dec;
                    if (remain_dec == '0) begin
                        n_phase = PH_CHECK;
                    end
                    o_push = 1'b1;
                end
                PH_CHECK: begin
                    o_entry.last   = 1'b1;
                    o_entry.sum_ok = (i_rx_byte == r_xor);
                    o_push         = 1'b1;
                    n_phase        = PH_ADDR;
                    n_xor          = '0;
                    n_remain       = '0;
                end
                default: begin
                    n_addr  = i_rx_byte;
                    n_xor   = i_rx_byte;
                    n_phase = PH_TYPE;
                end
            endcase
        end
    end

    // Hold the frame context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ADDR;
            r_addr   <= '0;
            r_type   <= '0;
            r_remain <= '0;
            r_xor    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_addr   <= n_addr;
            r_type   <= n_type;
            r_remain <= n_remain;
            r_xor    <= n_xor;
        end
    end

endmodule

FILE: rtl/tlvfr_queue.sv
module tlvfr_queue
    import tlvfr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_entry
);

    t_entry           r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCntW'(1);
                2'b01:   r_count <= r_count - QCntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCntW'(QDepth))
        else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("request popped from empty queue");
`endif

endmodule

FILE: rtl/tlvfr_back.sv
module tlvfr_back
    import tlvfr_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgW-1:0]     i_cfg_data,
    input  logic                i_q_empty,
    input  t_entry              i_entry,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DataW-1:0]    o_payload_byte,
    output logic [DataW-1:0]    o_frame_address,
    output logic [DataW-1:0]    o_frame_type,
    output logic [StatusW-1:0]  o_frame_status,
    output logic [SlotIdxW-1:0] o_slot_index,
    output logic                o_frame_end
);

    logic [CfgW-1:0]       r_slot [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] hit;
    logic [SlotIdxW-1:0]   hit_idx;
    t_status               status;
    logic [SlotIdxW-1:0]   idx;

    logic                  r_out_valid;
    logic [DataW-1:0]      r_payload;
    logic [DataW-1:0]      r_addr;
    logic [DataW-1:0]      r_type;
    t_status               r_status;
    logic [SlotIdxW-1:0]   r_idx;
    logic                  r_end;

    // Slot registers; writes beyond the last slot are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (i_cfg_index == CfgIdxW'(i)) begin
                    r_slot[i] <= i_cfg_data;
                end
            end
        end
    end

    // Compare every slot against the frame header
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            hit[i] = r_slot[i][SlotValidBit]
                && (r_slot[i][SlotAddrLo +: DataW] == i_entry.addr)
                && (r_slot[i][SlotTypeLo +: DataW] == i_entry.ftype);
        end
    end

    // Lowest matching slot wins
    always_comb begin
        hit_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = SlotIdxW'(i);
            end
        end
    end

    // Resolve frame status
    always_comb begin
        status = ST_DELIVERED;
        idx    = '0;
        if (i_entry.last) begin
            if (!i_entry.sum_ok) begin
                status = ST_MISMATCH;
            end else if (|hit) begin
                idx = hit_idx;
            end else begin
                status = ST_NO_SLOT;
            end
        end
    end

    assign o_pop = !i_q_empty && (!r_out_valid || i_out_ready);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_payload <= i_entry.last ? '0 : i_entry.data;
            r_addr    <= i_entry.addr;
            r_type    <= i_entry.ftype;
            r_status  <= status;
            r_idx     <= idx;
            r_end     <= i_entry.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_payload;
    assign o_frame_address = r_addr;
    assign o_frame_type    = r_type;
    assign o_frame_status  = r_status;
    assign o_slot_index    = r_idx;
    assign o_frame_end     = r_end;

`ifndef SYNTHESIS
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end && (o_frame_status == ST_DELIVERED))
        |-> ({1'b0, o_slot_index} < (SlotIdxW + 1)'(SLOT_COUNT)))
        else $error("delivered frame names a slot that does not exist");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_end)
        |-> ((o_frame_status == ST_DELIVERED) && (o_slot_index == '0)))
        else $error("payload result carries frame status");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
        |=> (o_out_valid && $stable({o_payload_byte, o_frame_address, o_frame_type,
                                     o_frame_status, o_slot_index, o_frame_end})))
        else $error("stalled result changed before it was taken");
`endif

endmodule

FILE: rtl/tlv_frame_receiver_xor.sv
// Frame receiver for a serial byte stream. Each frame is an address byte, a
// type byte, a length byte, that many payload bytes and a checksum byte equal
// to the XOR of all earlier bytes of the frame. Every payload byte is passed
// on with the frame's address and type; the checksum byte gives one result
// with o_frame_end high and a status: delivered (with the lowest matching slot
// in o_slot_index), checksum mismatch, or no matching slot. Header bytes give
// no result. The block takes one byte per clock cycle while the queue is not
// full (o_in_ready high); the result of a byte is written into the queue and
// then into the output register before it is offered. A front state machine
// tracks the frame and the running XOR, a two-entry queue hands payload and
// checksum requests to the back end, which compares the header against the
// slot registers and holds the result in an output register, so either side
// may stall without stopping the other at once. Slot registers are written
// through i_cfg_we/i_cfg_index/i_cfg_data, only while the block is idle (a
// rule for the user that the block does not enforce); bit 16 is valid, bits
// 15:8 type, bits 7:0 address; an index past the last slot is ignored.
module tlv_frame_receiver_xor
    import tlvfr_pkg::*;
#(
    parameter int SLOT_COUNT = SlotCountDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [DataW-1:0]    i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DataW-1:0]    o_payload_byte,
    output logic [DataW-1:0]    o_frame_address,
    output logic [DataW-1:0]    o_frame_type,
    output logic [StatusW-1:0]  o_frame_status,
    output logic [SlotIdxW-1:0] o_slot_index,
    output logic                o_frame_end,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgW-1:0]     i_cfg_data
);

    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    t_entry push_entry;
    t_entry head_entry;

    tlvfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    tlvfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    tlvfr_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_empty       (q_empty),
        .i_entry         (head_entry),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_byte  (o_payload_byte),
        .o_frame_address (o_frame_address),
        .o_frame_type    (o_frame_type),
        .o_frame_status  (o_frame_status),
        .o_slot_index    (o_slot_index),
        .o_frame_end     (o_frame_end)
    );

endmodule
